FILE: design/thread_wait_queue_assert.svh
// Assertion macros for the wait queue module.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef THREAD_WAIT_QUEUE_ASSERT_SVH
`define THREAD_WAIT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/twq_pkg.sv
package twq_pkg;

	localparam int ID_W            = 6;
	localparam int CNT_W           = 7;
	localparam int ID_SPACE        = 64;
	localparam int DEF_MAX_THREADS = 64;

	typedef enum logic [1:0] {
		CMD_ENQ      = 2'd0,
		CMD_WAKE_ONE = 2'd1,
		CMD_WAKE_ALL = 2'd2,
		CMD_REMOVE   = 2'd3
	} cmd_t;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

endpackage

FILE: design/twq_link_ram.sv
module twq_link_ram #(
	parameter int DEPTH = twq_pkg::DEF_MAX_THREADS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [twq_pkg::ID_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic [twq_pkg::ID_W-1:0] rdata
);

	logic [twq_pkg::ID_W-1:0] mem [DEPTH];
	logic [twq_pkg::ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/thread_wait_queue.sv
// FIFO wait list of thread ids kept as a linked list in a link memory.
// A request is taken when start is high and busy is low; it carries command
// and thread_id. Results appear on woken_id, status and last for exactly one
// cycle, marked by strobe, in the cycle after the step that produces them. The
// receiver cannot stall, so no result is ever held back.
// The block handles one request at a time and holds busy high meanwhile.
// Every link access goes through the single port pair of the link memory,
// whose read data is registered. Enqueue on an empty queue, and a refusal,
// finish in ST_ENQ1; otherwise ST_ENQ2 links the new id behind the tail.
// Wake one with more than one queued id reads the next head in ST_WAKE1_RD.
// Wake all gives one result per queued id, reading each link in ST_ALL_NX.
// Remove walks the list via ST_REM and ST_REM_NX; ST_REM_FIX relinks a match.
// The next request may be given in the cycle that shows the final result.
// Reset empties the queue; the link memory needs no clearing pass because
// a link is read only after it has been written.
module thread_wait_queue #(
	parameter int MAX_THREADS = twq_pkg::DEF_MAX_THREADS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic [twq_pkg::ID_W-1:0] thread_id,
	output logic                     strobe,
	output logic [twq_pkg::ID_W-1:0] woken_id,
	output logic                     status,
	output logic                     last
);

	localparam int AW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CAP = (MAX_THREADS < twq_pkg::ID_SPACE) ? MAX_THREADS : twq_pkg::ID_SPACE;
	localparam int IDW = twq_pkg::ID_W;
	localparam int CW  = twq_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ1,
		ST_ENQ2,
		ST_WAKE1,
		ST_WAKE1_RD,
		ST_ALL,
		ST_ALL_NX,
		ST_REM,
		ST_REM_NX,
		ST_REM_FIX
	} state_t;

	state_t          state_q;
	logic [IDW-1:0]  id_q;
	logic [IDW-1:0]  cur_q;
	logic [IDW-1:0]  prev_q;
	logic            has_prev_q;
	logic [CW-1:0]   idx_q;
	logic [IDW-1:0]  head_q;
	logic [IDW-1:0]  tail_q;
	logic [CW-1:0]   count_q;
	logic            strobe_q;
	logic [IDW-1:0]  woken_id_q;
	logic            status_q;
	logic            last_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [IDW-1:0]  ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [IDW-1:0]  ram_rdata;

	logic            refuse;
	logic            match;
	logic            has_next;
	logic            idx_last;
	logic            walk_end;
	logic [CW-1:0]   cnt_dec;
	logic [CW-1:0]   cnt_inc;

	twq_link_ram #(
		.DEPTH(MAX_THREADS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign refuse   = (32'(id_q) >= 32'(MAX_THREADS)) || (count_q >= CW'(CAP));
	assign match    = (cur_q == id_q);
	assign has_next = ((idx_q + CW'(1)) < count_q);
	assign idx_last = ((idx_q + CW'(1)) == count_q);
	assign walk_end = (idx_q >= count_q);
	assign cnt_dec  = count_q - CW'(1);
	assign cnt_inc  = count_q + CW'(1);

	assign ram_raddr = AW'(cur_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(id_q);
		ram_wdata = '0;
		case (state_q)
			ST_ENQ1: begin
				ram_we = !refuse;
			end
			ST_ENQ2: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(tail_q);
				ram_wdata = id_q;
			end
			ST_REM: begin
				ram_we    = !walk_end && match && !has_next && has_prev_q;
				ram_waddr = AW'(prev_q);
			end
			ST_REM_FIX: begin
				ram_we    = has_prev_q;
				ram_waddr = AW'(prev_q);
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			id_q       <= '0;
			cur_q      <= '0;
			prev_q     <= '0;
			has_prev_q <= 1'b0;
			idx_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			strobe_q   <= 1'b0;
			woken_id_q <= '0;
			status_q   <= twq_pkg::STAT_OK;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						id_q       <= thread_id;
						cur_q      <= head_q;
						prev_q     <= '0;
						has_prev_q <= 1'b0;
						idx_q      <= '0;
						case (twq_pkg::cmd_t'(command))
							twq_pkg::CMD_ENQ:      state_q <= ST_ENQ1;
							twq_pkg::CMD_WAKE_ONE: state_q <= ST_WAKE1;
							twq_pkg::CMD_WAKE_ALL: state_q <= ST_ALL;
							default:               state_q <= ST_REM;
						endcase
					end
				end
				ST_ENQ1: begin
					if (refuse) begin
						strobe_q   <= 1'b1;
						woken_id_q <= '0;
						status_q   <= twq_pkg::STAT_FAIL;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else if (count_q == '0) begin
						head_q     <= id_q;
						tail_q     <= id_q;
						count_q    <= cnt_inc;
						strobe_q   <= 1'b1;
						woken_id_q <= '0;
						status_q   <= twq_pkg::STAT_OK;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_ENQ2;
					end
				end
				ST_ENQ2: begin
					tail_q     <= id_q;
					count_q    <= cnt_inc;
					strobe_q   <= 1'b1;
					woken_id_q <= '0;
					status_q   <= twq_pkg::STAT_OK;
					last_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_WAKE1: begin
					if (count_q == '0) begin
						strobe_q   <= 1'b1;
						woken_id_q <= '0;
						status_q   <= twq_pkg::STAT_FAIL;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else if (count_q == CW'(1)) begin
						head_q     <= '0;
						tail_q     <= '0;
						count_q    <= '0;
						strobe_q   <= 1'b1;
						woken_id_q <= cur_q;
						status_q   <= twq_pkg::STAT_OK;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_WAKE1_RD;
					end
				end
				ST_WAKE1_RD: begin
					head_q     <= ram_rdata;
					count_q    <= cnt_dec;
					strobe_q   <= 1'b1;
					woken_id_q <= cur_q;
					status_q   <= twq_pkg::STAT_OK;
					last_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_ALL: begin
					strobe_q <= 1'b1;
					if (count_q == '0) begin
						woken_id_q <= '0;
						status_q   <= twq_pkg::STAT_FAIL;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						woken_id_q <= cur_q;
						status_q   <= twq_pkg::STAT_OK;
						last_q     <= idx_last;
						if (idx_last) begin
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ALL_NX;
						end
					end
				end
				ST_ALL_NX: begin
					cur_q   <= ram_rdata;
					idx_q   <= idx_q + CW'(1);
					state_q <= ST_ALL;
				end
				ST_REM: begin
					if (walk_end || (!match && !has_next)) begin
						strobe_q   <= 1'b1;
						woken_id_q <= '0;
						status_q   <= twq_pkg::STAT_FAIL;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else if (!match) begin
						state_q <= ST_REM_NX;
					end else if (has_next) begin
						state_q <= ST_REM_FIX;
					end else begin
						if (!has_prev_q) begin
							head_q <= '0;
						end
						if (tail_q == cur_q) begin
							tail_q <= has_prev_q ? prev_q : '0;
						end
						count_q <= cnt_dec;
						if (cnt_dec == '0) begin
							head_q <= '0;
							tail_q <= '0;
						end
						strobe_q   <= 1'b1;
						woken_id_q <= id_q;
						status_q   <= twq_pkg::STAT_OK;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_REM_NX: begin
					prev_q     <= cur_q;
					has_prev_q <= 1'b1;
					cur_q      <= ram_rdata;
					idx_q      <= idx_q + CW'(1);
					state_q    <= ST_REM;
				end
				ST_REM_FIX: begin
					if (!has_prev_q) begin
						head_q <= ram_rdata;
					end
					count_q    <= cnt_dec;
					strobe_q   <= 1'b1;
					woken_id_q <= id_q;
					status_q   <= twq_pkg::STAT_OK;
					last_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign strobe   = strobe_q;
	assign woken_id = woken_id_q;
	assign status   = status_q;
	assign last     = last_q;

`include "thread_wait_queue_assert.svh"

	`TWQ_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(CAP), "Entry count exceeds capacity.")
	`TWQ_ASSERT_NOW(a_empty_ptrs, count_q == '0, head_q == '0 && tail_q == '0, "Empty queue with stale pointers.")
	`TWQ_ASSERT_NOW(a_more_results, strobe_q && !last_q, busy, "Request ended before its final result.")
	`TWQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted request did not raise busy.")
	`TWQ_ASSERT_NOW(a_write_busy, ram_we, busy, "Link write while idle.")

endmodule
